[rtl/ffd_pkg.sv]
// ffd_pkg: widths, register indexes, shared types and the saturation helper
// for the fractional feedback delay. No dependencies.
package ffd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DELAY_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int WET_W      = 17;
    localparam int COEF_W     = 16;
    localparam int RING_AW    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SAT_IN_W   = SAMPLE_W + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEFF  = CFG_IDX_W'(3);

    localparam logic [COEF_W-1:0] SMOOTH_RESET = COEF_W'(2621);
    localparam logic [WET_W-1:0]  WET_ONE      = WET_W'(65536);
    localparam int                ROUND_SH     = 16;

    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic [DELAY_W-1:0] target_delay;
        logic [GAIN_W-1:0]  feedback_gain;
        logic [WET_W-1:0]   wet_mix;
        logic [COEF_W-1:0]  smooth_coeff;
    } t_cfg;

    typedef struct packed {
        logic                we;
        logic [RING_AW-1:0]  addr;
        logic [SAMPLE_W-1:0] data;
    } t_ring_wr;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SAT_IN_W-1:0] v
    );
        if (v > SAT_HI) begin
            return SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[SAMPLE_W-1:0];
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

[rtl/ffd_cfg.sv]
// ffd_cfg: configuration register file for the fractional feedback delay.
// Depends on ffd_pkg.
module ffd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ffd_pkg::t_cfg                  o_cfg
);
    import ffd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_delay  <= '0;
            r_cfg.feedback_gain <= '0;
            r_cfg.wet_mix       <= '0;
            r_cfg.smooth_coeff  <= SMOOTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_DELAY:  r_cfg.target_delay  <= i_cfg_data[DELAY_W-1:0];
                CFG_FEEDBACK_GAIN: r_cfg.feedback_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_WET_MIX:       r_cfg.wet_mix       <= i_cfg_data[WET_W-1:0];
                CFG_SMOOTH_COEFF:  r_cfg.smooth_coeff  <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/ffd_ring.sv]
// ffd_ring: delay ring memory, one write port and two registered read ports.
// Depends on ffd_pkg.
module ffd_ring (
    input  logic                         i_clk,
    input  ffd_pkg::t_ring_wr            i_wr,
    input  logic [ffd_pkg::RING_AW-1:0]  i_raddr_a,
    input  logic [ffd_pkg::RING_AW-1:0]  i_raddr_b,
    output logic [ffd_pkg::SAMPLE_W-1:0] o_rdata_a,
    output logic [ffd_pkg::SAMPLE_W-1:0] o_rdata_b
);
    import ffd_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [1 << RING_AW];
    logic [SAMPLE_W-1:0] r_rdata_a;
    logic [SAMPLE_W-1:0] r_rdata_b;

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/fractional_feedback_delay.sv]
// fractional_feedback_delay: feedback delay line with linear interpolation,
// smoothed delay and dry/wet mix. Depends on ffd_pkg, ffd_cfg, ffd_ring.
//
//   channel  valid        ready        payload
//   in       i_in_valid   o_in_ready   i_in_sample, i_block_start
//   out      o_out_valid  i_out_ready  o_out_sample
//   cfg      i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each word passes four steps: accept (delay smoothing on a block start), ring
// read and write, interpolation, mix. A new word is taken once the last leaves mix.
// Reset is synchronous; unwritten ring entries read as zero through a fill flag.
// A word waits in the mix step while the output register is still held.
// Config writes are taken every cycle.
module fractional_feedback_delay (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ffd_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                                i_block_start,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ffd_pkg::SAMPLE_W-1:0] o_out_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ffd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_INTERP = 2'd2;
    localparam logic [1:0] S_MIX    = 2'd3;

    localparam int SM_W = DELAY_W + 1 + COEF_W + 1;
    localparam int FB_W = SAMPLE_W + GAIN_W + 1;
    localparam int IP_W = SAMPLE_W + 1 + FRAC_BITS + 1;
    localparam int MX_W = SAMPLE_W + 1 + WET_W + 1;

    t_cfg     cfg;
    t_ring_wr ring_wr;

    logic [1:0]                 r_state;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [GAIN_W:0]     r_fbv;
    logic [DELAY_W-1:0]         r_sd;
    logic [RING_AW-1:0]         r_wp;
    logic                       r_filled;
    logic signed [SAMPLE_W-1:0] r_fs;
    logic signed [SAMPLE_W-1:0] r_rd;
    logic [FRAC_BITS-1:0]       r_t;
    logic                       r_v0;
    logic                       r_v1;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic                       accept;
    logic                       ld_out;
    logic signed [DELAY_W:0]    sm_diff;
    logic signed [SM_W-1:0]     sm_prod;
    logic signed [SM_W-1:0]     sm_rnd;
    logic [DELAY_W-1:0]         n_sd;
    logic signed [FB_W-1:0]     fb_prod;
    logic [RING_AW-1:0]         dint;
    logic [FRAC_BITS-1:0]       frac;
    logic [RING_AW-1:0]         base;
    logic [RING_AW-1:0]         ipos;
    logic [RING_AW-1:0]         i0;
    logic signed [SAMPLE_W+1:0] wsum;
    logic [SAMPLE_W-1:0]        rdata_a;
    logic [SAMPLE_W-1:0]        rdata_b;
    logic signed [SAMPLE_W-1:0] y0;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W:0]   ip_diff;
    logic signed [IP_W-1:0]     ip_prod;
    logic signed [SAMPLE_W+1:0] ip_sum;
    logic signed [SAMPLE_W-1:0] n_rd;
    logic [WET_W-1:0]           wet;
    logic signed [SAMPLE_W:0]   mx_diff;
    logic signed [MX_W-1:0]     mx_prod;
    logic signed [SAMPLE_W+2:0] mx_sum;
    logic signed [SAMPLE_W-1:0] n_mix;

    ffd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ffd_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_raddr_a (i0),
        .i_raddr_b (ipos),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign ld_out      = (r_state == S_MIX) && (!r_out_valid || i_out_ready);

    // one-pole step: sd + round((target - sd) * coeff / 2^16)
    assign sm_diff = $signed({1'b0, cfg.target_delay}) - $signed({1'b0, r_sd});
    assign sm_prod = sm_diff * $signed({1'b0, cfg.smooth_coeff});
    assign sm_rnd  = sm_prod + SM_W'(1 << (ROUND_SH - 1));
    assign n_sd    = r_sd + sm_rnd[ROUND_SH +: DELAY_W];

    assign fb_prod = r_fs * $signed({1'b0, cfg.feedback_gain});

    // read addresses
    assign dint = RING_AW'(r_sd[DELAY_W-1:FRAC_BITS]);
    assign frac = r_sd[FRAC_BITS-1:0];
    assign base = r_wp - dint;
    assign ipos = (frac == '0) ? base : base - RING_AW'(1);
    assign i0   = ipos - RING_AW'(1);

    assign wsum = SAMPLE_W'(0) + {{2{r_x[SAMPLE_W-1]}}, r_x} + {r_fbv[GAIN_W], r_fbv};

    assign ring_wr.we   = (r_state == S_READ);
    assign ring_wr.addr = r_wp;
    assign ring_wr.data = sat_sample(SAT_IN_W'(wsum));

    // interpolation: y0 + floor((y1 - y0) * t / 2^F)
    assign y0      = r_v0 ? $signed(rdata_a) : '0;
    assign y1      = r_v1 ? $signed(rdata_b) : '0;
    assign ip_diff = {y1[SAMPLE_W-1], y1} - {y0[SAMPLE_W-1], y0};
    assign ip_prod = ip_diff * $signed({1'b0, r_t});
    assign ip_sum  = {{2{y0[SAMPLE_W-1]}}, y0} + ip_prod[IP_W-1:FRAC_BITS];
    assign n_rd    = ip_sum[SAMPLE_W-1:0];

    // mix: x + floor((rd - x) * wet / 2^16)
    assign wet     = (cfg.wet_mix > WET_ONE) ? WET_ONE : cfg.wet_mix;
    assign mx_diff = {r_rd[SAMPLE_W-1], r_rd} - {r_x[SAMPLE_W-1], r_x};
    assign mx_prod = mx_diff * $signed({1'b0, wet});
    assign mx_sum  = {{3{r_x[SAMPLE_W-1]}}, r_x} + mx_prod[MX_W-1:ROUND_SH];
    assign n_mix   = sat_sample(SAT_IN_W'(mx_sum));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sd        <= '0;
            r_wp        <= '0;
            r_filled    <= 1'b0;
            r_fs        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_block_start) begin
                            r_sd <= n_sd;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_fs    <= n_rd;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    if (ld_out) begin
                        r_wp <= r_wp + RING_AW'(1);
                        if (r_wp == '1) begin
                            r_filled <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_in_sample;
            r_fbv <= fb_prod[FB_W-1:ROUND_SH];
        end
        if (r_state == S_READ) begin
            r_t  <= (~frac) + FRAC_BITS'(1);
            r_v0 <= r_filled || (i0 < r_wp);
            r_v1 <= r_filled || (ipos < r_wp);
        end
        if (r_state == S_INTERP) begin
            r_rd <= n_rd;
        end
        if (ld_out) begin
            r_out_sample <= n_mix;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

`ifndef SYNTHESIS
    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted word did not move to ring access");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_out |=> (r_wp == RING_AW'($past(r_wp) + RING_AW'(1))))
        else $error("write pointer did not advance by one");

    a_filled_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_filled))
        else $error("ring fill flag dropped");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MIX) && r_out_valid && !i_out_ready) |=> (r_state == S_MIX))
        else $error("result left mix step while output held");
`endif

endmodule

[bench/fractional_feedback_delay_tb.sv]
// fractional_feedback_delay_tb: self-checking bench for the feedback delay line.
// It predicts every output word from its own copy of the ring, the pointer and
// the glide state, and compares it. It depends on ffd_pkg and fractional_feedback_delay.
module fractional_feedback_delay_tb;
    import ffd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_IDX_W'(5);
    localparam int      RING_N        = 1 << RING_AW;
    localparam longint  FONE          = longint'(1) << FRAC_BITS;
    localparam longint  Q16_ONE       = 65536;
    localparam longint  Q16_HALF      = 32768;
    localparam int      GAIN_TOP      = 62259;
    localparam int      DELAY_TOP     = 16776703;
    localparam int      LONG_HOLD     = 240;
    localparam int      DRAIN_CYCLES  = 12;
    localparam int      RANDOM_PHASES = 10;
    localparam int      PHASE_WORDS   = 85;
    localparam int      TIMEOUT_UNITS = 3000000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_start;
    } t_word;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] in_sample   = '0;
    logic                       block_start = 1'b0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;

    // shadow state of the delay line
    logic signed [SAMPLE_W-1:0] ring_copy [RING_N];
    logic [RING_AW-1:0]         wr_ptr;
    logic [DELAY_W-1:0]         glide_delay;
    logic signed [SAMPLE_W-1:0] fb_sample;
    logic [DELAY_W-1:0]         cfg_target;
    logic [GAIN_W-1:0]          cfg_gain;
    logic [WET_W-1:0]           cfg_wet;
    logic [COEF_W-1:0]          cfg_coeff;

    t_word                      samples_to_send [$];
    logic signed [SAMPLE_W-1:0] out_samples_due [$];
    t_word                      next_word;
    logic signed [SAMPLE_W-1:0] want_sample;
    int                         send_gap       = 0;
    int                         hold_left      = 0;
    int                         mismatches     = 0;
    logic                       idle_send      = 1'b0;
    logic                       idle_recv      = 1'b0;
    logic                       long_hold_req  = 1'b0;
    logic                       long_hold_done = 1'b0;

    fractional_feedback_delay dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_sample   (in_sample),
        .i_block_start (block_start),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_sample  (out_sample),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return SAMPLE_W'(hi);
        end else if (v < lo) begin
            return SAMPLE_W'(lo);
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] compute_delay_output(
        input logic signed [SAMPLE_W-1:0] sample,
        input logic                       start
    );
        longint                        x, acc, y0, y1, rd, fb, mix, wet, dry, t;
        logic [DELAY_W-FRAC_BITS-1:0]  dint;
        logic [FRAC_BITS-1:0]          frac;
        logic [RING_AW-1:0]            ipos, i0;
        x = longint'(sample);
        if (start) begin
            acc = longint'(glide_delay) * (Q16_ONE - longint'(cfg_coeff))
                + longint'(cfg_target) * longint'(cfg_coeff) + Q16_HALF;
            glide_delay = DELAY_W'(acc >>> 16);
        end
        dint = glide_delay[DELAY_W-1:FRAC_BITS];
        frac = glide_delay[FRAC_BITS-1:0];
        if (frac == '0) begin
            t    = 0;
            ipos = RING_AW'(wr_ptr - dint);
        end else begin
            t    = FONE - longint'(frac);
            ipos = RING_AW'(wr_ptr - dint - 1'b1);
        end
        i0  = ipos - 1'b1;
        y0  = longint'(ring_copy[i0]);
        y1  = longint'(ring_copy[ipos]);
        rd  = (y0 * (FONE - t) + y1 * t) >>> FRAC_BITS;
        fb  = (longint'(fb_sample) * longint'(cfg_gain)) >>> 16;
        ring_copy[wr_ptr] = clip16(x + fb);
        fb_sample = SAMPLE_W'(rd);
        wet = (cfg_wet > WET_ONE) ? Q16_ONE : longint'(cfg_wet);
        dry = Q16_ONE - wet;
        mix = (x * dry + rd * wet) >>> 16;
        wr_ptr = wr_ptr + 1'b1;
        return clip16(mix);
    endfunction

    function automatic void set_shadow_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        case (idx)
            CFG_TARGET_DELAY: begin
                cfg_target = data[DELAY_W-1:0];
            end
            CFG_FEEDBACK_GAIN: begin
                cfg_gain = data[GAIN_W-1:0];
            end
            CFG_WET_MIX: begin
                cfg_wet = data[WET_W-1:0];
            end
            CFG_SMOOTH_COEFF: begin
                cfg_coeff = data[COEF_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        end else if (r == 1) begin
            return SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
        end
        return SAMPLE_W'($urandom());
    endfunction

    task automatic queue_word(input logic signed [SAMPLE_W-1:0] s, input logic start);
        t_word w;
        w.sample      = s;
        w.block_start = start;
        samples_to_send.push_back(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        set_shadow_reg(idx, data);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || in_valid || out_samples_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                out_samples_due.push_back(compute_delay_output(in_sample, block_start));
            end
            if (!in_valid || in_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (samples_to_send.size() != 0) begin
                    next_word = samples_to_send.pop_front();
                    in_sample   <= next_word.sample;
                    block_start <= next_word.block_start;
                    in_valid    <= 1'b1;
                    if (idle_send && $urandom_range(0, 4) == 0) begin
                        send_gap <= $urandom_range(1, 18);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            out_ready      <= 1'b0;
        end else if (idle_recv && $urandom_range(0, 6) == 0) begin
            hold_left <= $urandom_range(0, 17);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // output check
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (out_samples_due.size() == 0) begin
                $error("out_sample: expected none, actual %0d", out_sample);
                mismatches++;
            end else begin
                want_sample = out_samples_due.pop_front();
                if (out_sample !== want_sample) begin
                    $error("out_sample: expected %0d, actual %0d", want_sample, out_sample);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int r, len, n;
        logic [CFG_DATA_W-1:0] v;
        for (int i = 0; i < RING_N; i++) ring_copy[i] = '0;
        wr_ptr      = '0;
        glide_delay = '0;
        fb_sample   = '0;
        cfg_target  = '0;
        cfg_gain    = '0;
        cfg_wet     = '0;
        cfg_coeff   = SMOOTH_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero delay, all dry
        queue_word(16'sh7FFF, 1'b1);
        queue_word(16'sh8000, 1'b0);
        queue_word(16'sd0, 1'b0);
        queue_word(-16'sd1, 1'b1);
        queue_word(16'sd1, 1'b0);
        wait_drained();

        // short fractional delay, full gain, wet above unity, saturating feedback
        write_reg(CFG_TARGET_DELAY, (24'd2 << FRAC_BITS) | 24'h40);
        write_reg(CFG_FEEDBACK_GAIN, 24'hFFFF);
        write_reg(CFG_WET_MIX, 24'h1FFFF);
        write_reg(CFG_SMOOTH_COEFF, 24'hFFFF);
        queue_word(16'sh7FFF, 1'b1);
        repeat (7) queue_word(16'sh7FFF, 1'b0);
        repeat (3) queue_word(16'sh8000, 1'b0);
        queue_word(16'sh5555, 1'b0);
        wait_drained();

        // unused index, longest delay, frozen glide
        write_reg(CFG_NO_REG, 24'hFFFFFF);
        write_reg(CFG_TARGET_DELAY, CFG_DATA_W'(DELAY_TOP));
        write_reg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(GAIN_TOP));
        write_reg(CFG_WET_MIX, 24'h10000);
        write_reg(CFG_SMOOTH_COEFF, 24'h0);
        queue_word(16'sd12345, 1'b1);
        queue_word(-16'sd12345, 1'b0);
        wait_drained();
        write_reg(CFG_SMOOTH_COEFF, 24'hFFFF);
        queue_word(16'sh7FFF, 1'b1);
        queue_word(16'sh8000, 1'b0);
        queue_word(16'sh2AAA, 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 9);
            if (r == 0) v = '0;
            else if (r == 1) v = 24'hFFFFFF;
            else if (r == 2) v = CFG_DATA_W'(DELAY_TOP);
            else if (r == 3) v = CFG_DATA_W'($urandom());
            else v = CFG_DATA_W'($urandom_range(0, 40 << FRAC_BITS));
            write_reg(CFG_TARGET_DELAY, v);

            r = $urandom_range(0, 4);
            if (r == 0) v = '0;
            else if (r == 1) v = CFG_DATA_W'(GAIN_TOP);
            else if (r == 2) v = 24'hFFFF;
            else if (r == 3) v = CFG_DATA_W'($urandom());
            else v = CFG_DATA_W'($urandom_range(0, GAIN_TOP));
            write_reg(CFG_FEEDBACK_GAIN, v);

            r = $urandom_range(0, 4);
            if (r == 0) v = '0;
            else if (r == 1) v = 24'h10000;
            else if (r == 2) v = 24'h1FFFF;
            else if (r == 3) v = CFG_DATA_W'($urandom());
            else v = CFG_DATA_W'($urandom_range(0, 65536));
            write_reg(CFG_WET_MIX, v);

            r = $urandom_range(0, 4);
            if (r == 0) v = '0;
            else if (r == 1) v = 24'hFFFF;
            else if (r == 2) v = CFG_DATA_W'(SMOOTH_RESET);
            else if (r == 3) v = CFG_DATA_W'($urandom());
            else v = CFG_DATA_W'($urandom_range(0, 65535));
            write_reg(CFG_SMOOTH_COEFF, v);

            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_NO_REG, CFG_DATA_W'($urandom()));
            end

            @(posedge i_clk);
            if (p == RANDOM_PHASES - 1) begin
                idle_send <= 1'b0;
                idle_recv <= 1'b0;
            end else if (p == 2) begin
                idle_send     <= 1'b0;
                idle_recv     <= 1'b0;
                long_hold_req <= 1'b1;
            end else begin
                r = $urandom_range(0, 3);
                idle_send <= r[0];
                idle_recv <= r[1];
            end

            // blocks headed by a start flag; some are broken or carry a stray flag
            n = 0;
            while (n < PHASE_WORDS) begin
                len = $urandom_range(1, 24);
                r   = $urandom_range(0, 9);
                for (int j = 0; j < len; j++) begin
                    queue_word(pick_sample(),
                               (j == 0 && r != 0) || (r == 1 && $urandom_range(0, 7) == 0));
                end
                n += len;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/ffd_pkg.sv
rtl/ffd_cfg.sv
rtl/ffd_ring.sv
rtl/fractional_feedback_delay.sv
bench/fractional_feedback_delay_tb.sv
